>>> hdl/holdoff_priority_slot_scheduler_assert.svh
// Assertion macros for the holdoff priority slot scheduler.
// Included by the top level; depends on signals named clock and reset in scope.
`ifndef HOLDOFF_PRIORITY_SLOT_SCHEDULER_ASSERT_SVH
`define HOLDOFF_PRIORITY_SLOT_SCHEDULER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define HPS_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("scheduler assertion failed");

// Next-cycle implication, checked outside reset
`define HPS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("scheduler assertion failed");

`endif

>>> hdl/hps_pkg.sv
// Shared widths, codes and lane control types for the holdoff priority slot scheduler.
// No dependencies; used by every module of the block.
`default_nettype none

package hps_pkg;

   localparam int MAX_ENTRIES_DEF = 16;

   localparam int IDX_W    = 4;
   localparam int DEMAND_W = 16;
   localparam int GAP_W    = 8;
   localparam int COOL_W   = 9;
   localparam int SERVED_W = 5;
   localparam int SLOT_W   = 16;
   localparam int ACTIVE_W = 5;
   localparam int AMOUNT_W = 16;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 24;

   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   localparam logic [CSR_ADDR_W-1:0] CSR_ACTIVE_ENTRIES  = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_AMOUNT_PER_SLOT = 1'b1;

   typedef struct packed {
      logic active;
      logic load;
      logic tick;
      logic grant;
   } lane_ctrl_type;

   typedef struct packed {
      logic [DEMAND_W-1:0] demand;
      logic [GAP_W-1:0]    gap;
   } lane_load_type;

   typedef struct packed {
      logic eligible;
      logic pending;
   } lane_stat_type;

endpackage

`default_nettype wire

>>> hdl/hps_lane.sv
// One scheduler entry: remaining demand, hold-off gap and cooldown, with load,
// serve and per-slot cooldown update. Depends on hps_pkg.
`default_nettype none

module hps_lane (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire hps_pkg::lane_ctrl_type         ctrl,
   input  wire hps_pkg::lane_load_type         load_data,
   input  wire logic [hps_pkg::AMOUNT_W-1:0]   amount,
   output hps_pkg::lane_stat_type              stat
);

   logic [hps_pkg::DEMAND_W-1:0] demand_ff, demand_in;
   logic [hps_pkg::GAP_W-1:0]    gap_ff, gap_in;
   logic [hps_pkg::COOL_W-1:0]   cool_ff, cool_in;

   always_comb begin
      demand_in = demand_ff;
      gap_in    = gap_ff;
      cool_in   = cool_ff;
      if (ctrl.load) begin
         demand_in = load_data.demand;
         gap_in    = load_data.gap;
         cool_in   = '0;
      end else if (ctrl.tick) begin
         if (ctrl.grant) begin
            // saturate at zero; cooldown of gap+1 already drops by one this slot
            demand_in = (demand_ff > amount) ? demand_ff - amount : '0;
            cool_in   = {1'b0, gap_ff};
         end else if (cool_ff != '0) begin
            cool_in = cool_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         demand_ff <= '0;
         gap_ff    <= '0;
         cool_ff   <= '0;
      end else begin
         demand_ff <= demand_in;
         gap_ff    <= gap_in;
         cool_ff   <= cool_in;
      end
   end

   assign stat.eligible = ctrl.active && (cool_ff == '0) && (demand_ff != '0);
   assign stat.pending  = ctrl.active && (demand_in != '0);

endmodule

`default_nettype wire

>>> hdl/hps_prio.sv
// Fixed-priority grant over the eligible entries, lowest index wins.
// Depends on hps_pkg for the served-entry width.
`default_nettype none

module hps_prio #(
   parameter int N = hps_pkg::MAX_ENTRIES_DEF
) (
   input  wire logic [N-1:0]                  eligible,
   output logic [N-1:0]                       grant,
   output logic [hps_pkg::SERVED_W-1:0]       served_entry
);

   localparam int IDXW = $clog2(N);

   logic [IDXW-1:0] idx;

   // isolate the lowest set bit
   assign grant = eligible & (~eligible + N'(1));

   always_comb begin
      idx = '0;
      for (int i = N - 1; i >= 0; i--) begin
         if (eligible[i]) idx = IDXW'(i);
      end
   end

   assign served_entry = (eligible != '0)
                         ? hps_pkg::SERVED_W'({1'b0, idx} + (IDXW + 1)'(1))
                         : '0;

endmodule

`default_nettype wire

>>> hdl/holdoff_priority_slot_scheduler.sv
// Top level of the holdoff priority slot scheduler: input register, entry lanes,
// priority grant and result register. Depends on hps_pkg, hps_lane, hps_prio.
//
//   channel   direction  handshake          payload
//   req       in         tvalid/tready      tuser: cmd; tdata: index, demand, gap
//   rsp       out        tvalid/tready      tdata: served, slot, all_served
//   csr       in         we (no wait)       addr, wdata
//
// One transaction a cycle while the result is not stalled: an item is held in
// the input register, and a tick is resolved from there (eligibility, grant,
// decrement) into the result register. Loads produce no result. Synchronous
// reset clears all entries and restores both CSR registers to one. A stalled
// result holds tick items in the input register; loads still pass.
`default_nettype none

module holdoff_priority_slot_scheduler #(
   parameter int MAX_ENTRIES = hps_pkg::MAX_ENTRIES_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // req_tdata: entry_index[3:0], demand[19:4], gap_ticks[27:20], zero[31:28]
   input  wire logic [hps_pkg::REQ_DATA_W-1:0]      req_tdata,
   // req_tuser: cmd[0]
   input  wire logic                                req_tuser,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // rsp_tdata: served_entry[4:0], slot_number[20:5], all_served[21], zero[23:22]
   output logic [hps_pkg::RSP_DATA_W-1:0]           rsp_tdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   input  wire logic                                csr_we,
   input  wire logic [hps_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  wire logic [hps_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   `include "holdoff_priority_slot_scheduler_assert.svh"

   logic                          s1_valid_ff;
   logic                          s1_cmd_ff;
   logic [hps_pkg::IDX_W-1:0]     s1_idx_ff;
   hps_pkg::lane_load_type        s1_load_ff;

   logic [hps_pkg::ACTIVE_W-1:0]  active_ff;
   logic [hps_pkg::AMOUNT_W-1:0]  amount_ff;
   logic [hps_pkg::SLOT_W-1:0]    slot_ff;

   logic                          rsp_valid_ff;
   logic [hps_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   logic                          s1_go;
   logic                          tick_go;
   logic                          load_go;

   logic [MAX_ENTRIES-1:0]        eligible;
   logic [MAX_ENTRIES-1:0]        pending;
   logic [MAX_ENTRIES-1:0]        grant;
   logic [hps_pkg::SERVED_W-1:0]  served_entry;
   hps_pkg::lane_ctrl_type        lane_ctrl [MAX_ENTRIES];
   hps_pkg::lane_stat_type        lane_stat [MAX_ENTRIES];

   // a tick needs room in the result register; a load never does
   assign s1_go = s1_valid_ff
                  && ((s1_cmd_ff == hps_pkg::CMD_LOAD) || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_go;
   assign tick_go = s1_go && (s1_cmd_ff == hps_pkg::CMD_TICK);
   assign load_go = s1_go && (s1_cmd_ff == hps_pkg::CMD_LOAD)
                    && (int'(s1_idx_ff) < MAX_ENTRIES);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_cmd_ff         <= req_tuser;
         s1_idx_ff         <= req_tdata[3:0];
         s1_load_ff.demand <= req_tdata[19:4];
         s1_load_ff.gap    <= req_tdata[27:20];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= hps_pkg::ACTIVE_W'(1);
         amount_ff <= hps_pkg::AMOUNT_W'(1);
      end else if (csr_we) begin
         case (csr_addr)
            hps_pkg::CSR_ACTIVE_ENTRIES: begin
               active_ff <= csr_wdata[hps_pkg::ACTIVE_W-1:0];
            end
            hps_pkg::CSR_AMOUNT_PER_SLOT: begin
               amount_ff <= csr_wdata[hps_pkg::AMOUNT_W-1:0];
            end
            default: begin
               active_ff <= active_ff;
            end
         endcase
      end
   end

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_lane
      assign lane_ctrl[i].active = (int'(active_ff) > i);
      assign lane_ctrl[i].load   = load_go && (int'(s1_idx_ff) == i);
      assign lane_ctrl[i].tick   = tick_go;
      assign lane_ctrl[i].grant  = grant[i];
      assign eligible[i] = lane_stat[i].eligible;
      assign pending[i]  = lane_stat[i].pending;

      hps_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (lane_ctrl[i]),
         .load_data (s1_load_ff),
         .amount    (amount_ff),
         .stat      (lane_stat[i])
      );
   end

   hps_prio #(
      .N (MAX_ENTRIES)
   ) u_prio (
      .eligible     (eligible),
      .grant        (grant),
      .served_entry (served_entry)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else if (load_go) begin
         slot_ff <= '0;
      end else if (tick_go) begin
         slot_ff <= slot_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (tick_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (tick_go) begin
         rsp_data_ff <= {2'b00, ~(|pending), slot_ff, served_entry};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `HPS_ASSERT_SAME(a_grant_onehot, 1'b1, $onehot0(grant))
   `HPS_ASSERT_SAME(a_grant_eligible, 1'b1, (grant & ~eligible) == '0)
   `HPS_ASSERT_NEXT(a_tick_result, tick_go, rsp_tvalid)
   `HPS_ASSERT_NEXT(a_slot_advance, tick_go, slot_ff == $past(slot_ff) + 1'b1)

endmodule

`default_nettype wire
